/* rtl/mhp_pkg.sv */
// Package for the MOT header parser: payload structs, status codes, parse phases, parameter IDs.
// No dependencies.
`default_nettype none
package mhp_pkg;
  typedef struct packed {
    logic       func;
    logic [7:0] header_byte;
    logic       last_byte;
  } mhp_in_t;

  typedef struct packed {
    logic        kind;
    logic [5:0]  par_id;
    logic [14:0] byte_index;
    logic [7:0]  param_byte;
    logic [3:0]  status;
    logic [27:0] body_len;
    logic [5:0]  main_type;
    logic [7:0]  sub_type;
    logic        trigger_now;
    logic [7:0]  expire_byte;
    logic [7:0]  category;
    logic [7:0]  slide_num;
  } mhp_out_t;

  typedef enum logic [2:0] {
    PH_CORE = 3'd0, PH_HEAD = 3'd1, PH_LEN1 = 3'd2, PH_LEN2 = 3'd3, PH_DATA = 3'd4
  } mhp_phase_t;

  localparam logic [3:0] ST_OK = 4'd0, ST_SHORT = 4'd1, ST_SIZE = 4'd2, ST_ORDER = 4'd3,
    ST_TRUNC = 4'd4, ST_TRIG = 4'd5, ST_NAME = 4'd6, ST_VER = 4'd7, ST_CHANGED = 4'd8;

  localparam logic [5:0] PID_EXPIRE = 6'd4, PID_TRIGGER = 6'd5, PID_NAME = 6'd12,
    PID_VERSION = 6'd13, PID_CATSLIDE = 6'h25;
endpackage
`default_nettype wire

/* rtl/mhp_ram.sv */
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module mhp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* rtl/mot_header_parser.sv */
// MOT header parser: one header byte per transfer, at most two results per byte
// (a parameter data byte and, on the last byte, the summary). Results are registered
// into a two-entry output queue whose head is out_data; a byte is taken whenever the queue
// is empty, or holds one entry that leaves in the same cycle, so the rate is one byte
// per cycle while the output side keeps up. The content name lives in a NAME_BYTES x 8
// RAM; its read address follows the data position, so the entry for the next name byte
// is already on the read port when that byte arrives and an update header compares it
// in the same cycle.
// Depends on mhp_pkg and mhp_ram.
`default_nettype none
module mot_header_parser #(
  parameter int NAME_BYTES = 128
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire mhp_pkg::mhp_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output mhp_pkg::mhp_out_t     out_data,
  input  wire logic             cfg_we,
  input  wire logic [13:0]      cfg_wdata
);
  import mhp_pkg::*;
  localparam int AW = $clog2(NAME_BYTES);

  logic [13:0] upd_type_r;
  logic        header_seen_r, header_seen_nxt;
  logic [13:0] byte_count_r, byte_count_nxt;
  logic [27:0] body_r, body_nxt;
  logic [12:0] hsize_r, hsize_nxt;
  logic [13:0] ctype_r, ctype_nxt;
  mhp_phase_t  phase_r, phase_nxt;
  logic [5:0]  pid_r, pid_nxt;
  logic [14:0] left_r, left_nxt, pos_r, pos_nxt;
  logic [3:0]  err_r, err_nxt;
  logic        trig_r, trig_nxt;
  logic [7:0]  exp_r, exp_nxt, cat_r, cat_nxt, sld_r, sld_nxt;
  logic [14:0] slen_r, slen_nxt, nlen_r, nlen_nxt;
  logic        diff_r, diff_nxt;

  // output queue, two entries
  mhp_out_t q_r [2];
  logic [1:0] qcnt_r;

  logic acc, cnt0, upd, eff;
  logic [7:0] b;
  logic [13:0] cnt;
  logic [14:0] k;
  logic ram_we;
  logic [AW-1:0] ram_addr;
  logic [AW-1:0] rd_addr;
  logic [7:0] ram_q;
  logic emit_d, emit_s;
  mhp_out_t res_d, res_s;
  logic [3:0] st;

  assign in_ready = (qcnt_r == 2'd0) || (qcnt_r == 2'd1 && out_ready);
  assign acc = in_valid && in_ready;
  assign b = in_data.header_byte;
  assign out_valid = (qcnt_r != 2'd0);
  assign out_data = q_r[0];

  mhp_ram #(.WIDTH(8), .DEPTH(NAME_BYTES)) u_name (
    .clk(clk), .we(ram_we), .waddr(ram_addr), .wdata(b), .raddr(rd_addr), .rdata(ram_q)
  );

  always_comb begin
    logic [14:0] len;
    logic        bd;
    logic [14:0] fin_len;
    logic        fin;
    logic [14:0] rd_k;
    header_seen_nxt = header_seen_r; byte_count_nxt = byte_count_r;
    body_nxt = body_r; hsize_nxt = hsize_r; ctype_nxt = ctype_r; phase_nxt = phase_r;
    pid_nxt = pid_r; left_nxt = left_r; pos_nxt = pos_r; err_nxt = err_r;
    trig_nxt = trig_r; exp_nxt = exp_r; cat_nxt = cat_r; sld_nxt = sld_r;
    slen_nxt = slen_r; nlen_nxt = nlen_r; diff_nxt = diff_r;
    ram_we = 1'b0; ram_addr = '0;
    emit_d = 1'b0; emit_s = 1'b0; res_d = '0; res_s = '0; st = ST_OK;
    len = '0; bd = 1'b0; fin = 1'b0; fin_len = '0; k = '0;
    cnt = byte_count_r; cnt0 = 1'b0; upd = 1'b0; eff = 1'b0;
    if (acc) begin
      if (in_data.func) begin
        header_seen_nxt = 1'b0; slen_nxt = '0; byte_count_nxt = '0; phase_nxt = PH_CORE;
      end else begin
        cnt0 = (byte_count_r == 14'd0);
        if (cnt0) begin
          trig_nxt = 1'b1; exp_nxt = '0; cat_nxt = '0; sld_nxt = '0; err_nxt = ST_OK;
          nlen_nxt = '0; diff_nxt = 1'b0; phase_nxt = PH_CORE;
        end
        upd = (ctype_nxt == upd_type_r);
        eff = (err_nxt == ST_OK) && (header_seen_r == upd);
        unique case (phase_nxt)
          PH_CORE: begin
            unique case (byte_count_r)
              14'd0: body_nxt = {b, 20'd0};
              14'd1: body_nxt[19:12] = b;
              14'd2: body_nxt[11:4] = b;
              14'd3: begin body_nxt[3:0] = b[7:4]; hsize_nxt = {b[3:0], 9'd0}; end
              14'd4: hsize_nxt[8:1] = b;
              14'd5: begin hsize_nxt[0] = b[7]; ctype_nxt = {b[6:1], 8'd0}; end
              default: begin ctype_nxt[7:0] = b; phase_nxt = PH_HEAD; end
            endcase
          end
          PH_HEAD: begin
            pid_nxt = b[5:0];
            unique case (b[7:6])
              2'd0: begin fin = 1'b1; fin_len = '0; end
              2'd1: begin bd = 1'b1; len = 15'd1; end
              2'd2: begin bd = 1'b1; len = 15'd4; end
              default: phase_nxt = PH_LEN1;
            endcase
          end
          PH_LEN1: begin
            if (b[7]) begin left_nxt = {8'd0, b[6:0]}; phase_nxt = PH_LEN2; end
            else begin bd = 1'b1; len = {8'd0, b[6:0]}; end
          end
          PH_LEN2: begin bd = 1'b1; len = {left_r[6:0], b}; end
          PH_DATA: begin
            emit_d = 1'b1;
            res_d.par_id = pid_r; res_d.byte_index = pos_r; res_d.param_byte = b;
            if (eff) begin
              if (pid_r == PID_EXPIRE && pos_r == 15'd0) exp_nxt = b;
              if (pid_r == PID_TRIGGER && pos_r == 15'd0) trig_nxt = ~b[7];
              if (pid_r == PID_CATSLIDE && pos_r == 15'd0) cat_nxt = b;
              if (pid_r == PID_CATSLIDE && pos_r == 15'd1) sld_nxt = b;
            end
            k = pos_r - 15'd1;
            if (pid_r == PID_NAME && pos_r != 15'd0 && k < 15'(NAME_BYTES)) begin
              ram_addr = k[AW-1:0];
              // ram_q already holds entry k, read while the previous byte was taken
              if (upd) begin
                if (k >= slen_r || ram_q != b) diff_nxt = 1'b1;
              end else if (eff) ram_we = 1'b1;
            end
            left_nxt = left_r - 15'd1;
            pos_nxt = pos_r + 15'd1;
            if (left_nxt == 15'd0) begin fin = 1'b1; fin_len = pos_r + 15'd1; end
          end
          default: phase_nxt = PH_CORE;
        endcase
        if (bd) begin
          if (eff) begin
            if (pid_nxt == PID_EXPIRE) exp_nxt = '0;
            if (pid_nxt == PID_CATSLIDE) begin cat_nxt = '0; sld_nxt = '0; end
          end
          if (pid_nxt == PID_NAME) begin
            if (upd) begin
              nlen_nxt = (len != 15'd0) ? len - 15'd1 : '0; diff_nxt = 1'b0;
            end else if (eff) slen_nxt = (len != 15'd0) ? len - 15'd1 : '0;
          end
          if (len == 15'd0) begin fin = 1'b1; fin_len = '0; end
          else begin left_nxt = len; pos_nxt = '0; phase_nxt = PH_DATA; end
        end
        if (fin) begin
          if (err_nxt == ST_OK) begin
            if (pid_nxt == PID_TRIGGER && fin_len < 15'd4) err_nxt = ST_TRIG;
            else if (pid_nxt == PID_NAME && fin_len == 15'd0) err_nxt = ST_NAME;
            else if (pid_nxt == PID_VERSION && fin_len != 15'd4) err_nxt = ST_VER;
          end
          phase_nxt = PH_HEAD;
        end
        if (cnt != 14'h3FFF) cnt = cnt + 14'd1;
        byte_count_nxt = cnt;
        // content type may have just been completed by a core byte
        upd = (ctype_nxt == upd_type_r);
        if (in_data.last_byte) begin
          emit_s = 1'b1;
          if ((phase_nxt == PH_LEN1 || phase_nxt == PH_LEN2 || phase_nxt == PH_DATA)
              && err_nxt == ST_OK) err_nxt = ST_TRUNC;
          if (cnt < 14'd7) st = ST_SHORT;
          else if ({1'b0, hsize_nxt} != cnt) st = ST_SIZE;
          else if (header_seen_r != upd) st = ST_ORDER;
          else if (err_nxt != ST_OK) st = err_nxt;
          else if (upd && (diff_nxt || nlen_nxt != slen_nxt)) st = ST_CHANGED;
          if (st == ST_OK && !upd) header_seen_nxt = 1'b1;
          res_s.kind = 1'b1; res_s.status = st; res_s.body_len = body_nxt;
          res_s.main_type = ctype_nxt[13:8]; res_s.sub_type = ctype_nxt[7:0];
          res_s.trigger_now = trig_nxt; res_s.expire_byte = exp_nxt;
          res_s.category = cat_nxt; res_s.slide_num = sld_nxt;
          byte_count_nxt = '0; phase_nxt = PH_CORE;
        end
      end
    end
    // prefetch the name entry for the next data position
    rd_k = pos_nxt - 15'd1;
    rd_addr = rd_k[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upd_type_r <= 14'd1280; header_seen_r <= 1'b0; byte_count_r <= '0;
      body_r <= '0; hsize_r <= '0; ctype_r <= '0; phase_r <= PH_CORE; pid_r <= '0;
      left_r <= '0; pos_r <= '0; err_r <= '0; trig_r <= 1'b0; exp_r <= '0;
      cat_r <= '0; sld_r <= '0; slen_r <= '0; nlen_r <= '0; diff_r <= 1'b0;
      qcnt_r <= '0;
    end else begin
      if (cfg_we) upd_type_r <= cfg_wdata;
      header_seen_r <= header_seen_nxt; byte_count_r <= byte_count_nxt;
      body_r <= body_nxt; hsize_r <= hsize_nxt; ctype_r <= ctype_nxt;
      phase_r <= phase_nxt; pid_r <= pid_nxt; left_r <= left_nxt; pos_r <= pos_nxt;
      err_r <= err_nxt; trig_r <= trig_nxt; exp_r <= exp_nxt; cat_r <= cat_nxt;
      sld_r <= sld_nxt; slen_r <= slen_nxt; nlen_r <= nlen_nxt; diff_r <= diff_nxt;
      qcnt_r <= qcnt_r - 2'((out_valid && out_ready) ? 1 : 0)
                + 2'(emit_d ? 1 : 0) + 2'(emit_s ? 1 : 0);
    end
  end

  // queue payload
  always_ff @(posedge clk) begin
    mhp_out_t a0, a1;
    logic [1:0] base;
    a0 = q_r[0]; a1 = q_r[1];
    base = qcnt_r;
    if (out_valid && out_ready) begin a0 = a1; base = base - 2'd1; end
    if (emit_d) begin
      if (base == 2'd0) a0 = res_d; else a1 = res_d;
      base = base + 2'd1;
    end
    if (emit_s) begin
      if (base == 2'd0) a0 = res_s; else a1 = res_s;
    end
    q_r[0] <= a0; q_r[1] <= a1;
  end

  assert property (@(posedge clk) disable iff (!rst_n) qcnt_r != 2'd3)
    else $error("output queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n) in_ready |-> qcnt_r != 2'd2 || out_ready)
    else $error("ready with full queue");
  assert property (@(posedge clk) disable iff (!rst_n) emit_s |-> !in_data.func)
    else $error("summary on new-object item");
  assert property (@(posedge clk) disable iff (!rst_n) ram_we |-> !upd)
    else $error("name write on update header");
  assert property (@(posedge clk) disable iff (!rst_n)
                   out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed while waiting");
endmodule
`default_nettype wire
